// ----- rtl/lru_key_value_cache_unit_macros.svh -----
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// Same-cycle implication
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ----- rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int CAPACITY_DEF  = 8;
    localparam int KEY_BITS_DEF  = 32;
    localparam int DATA_BITS_DEF = 32;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic look;       // compare phase: latch match and slot selects
        logic put_new;    // update phase: put of an absent key
        logic use_lru;    // put_new into a full store: reuse least recent
        logic get_hit;    // update phase: get that hit
        logic erase_hit;  // update phase: erase that hit
    } cell_ctrl_t;

endpackage

// ----- rtl/lru_key_value_cache_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Issue an item by raising start while busy is low; func selects put, get or
// erase. Every item keeps busy high for a compare pass along the row of
// entry cells, then an update pass, and its result appears on found and
// data_out, flagged by done for exactly one cycle, as busy falls; the
// receiver must take it then, as there is no way to hold it off.
// A new item may be issued in that same cycle, so the block takes a new item
// as soon as the last one is through; start is ignored while busy is high.
// The store is empty after reset. found is 1 for a valid func when the key was
// present before the item (for a put this means the put was rejected and
// nothing changed); data_out is the stored value on a get hit and zero otherwise.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
    parameter int CAPACITY  = lkvc_pkg::CAPACITY_DEF,
    parameter int KEY_BITS  = lkvc_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = lkvc_pkg::DATA_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           func,
    input  logic [KEY_BITS-1:0]  key,
    input  logic [DATA_BITS-1:0] data_in,
    output logic                 done,
    output logic                 found,
    output logic [DATA_BITS-1:0] data_out
);
    import lkvc_pkg::*;

    localparam int RANK_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // One-hot sequencer
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_UPDT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Item captured at issue
    logic [1:0]           op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] data_reg;

    // Compare-pass summary
    logic                 hit_reg;
    logic                 full_reg;
    logic [RANK_BITS-1:0] hit_rank_reg;
    logic [DATA_BITS-1:0] hit_data_reg;

    // Result register
    logic                 done_reg;
    logic                 found_reg;
    logic [DATA_BITS-1:0] data_out_reg;

    // Chains along the cell row
    logic                 hit_chain   [CAPACITY+1];
    logic                 free_chain  [CAPACITY+1];
    logic [RANK_BITS-1:0] rank_chain  [CAPACITY+1];
    logic [DATA_BITS-1:0] rdata_chain [CAPACITY+1];

    cell_ctrl_t ctrl;
    logic       accept;
    logic       op_valid;

    assign accept   = start && (state_reg == ST_IDLE);
    assign op_valid = op_reg inside {OP_PUT, OP_GET, OP_ERASE};

    always_comb
    begin
        ctrl           = '0;
        ctrl.look      = (state_reg == ST_LOOK);
        if (state_reg == ST_UPDT)
        begin
            ctrl.put_new   = (op_reg == OP_PUT) && !hit_reg;
            ctrl.use_lru   = full_reg;
            ctrl.get_hit   = (op_reg == OP_GET) && hit_reg;
            ctrl.erase_hit = (op_reg == OP_ERASE) && hit_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_UPDT;
            ST_UPDT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign hit_chain[0]   = 1'b0;
    assign free_chain[0]  = 1'b0;
    assign rank_chain[0]  = '0;
    assign rdata_chain[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lkvc_cell #(
            .CAPACITY  (CAPACITY),
            .KEY_BITS  (KEY_BITS),
            .DATA_BITS (DATA_BITS),
            .RANK_BITS (RANK_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .key_q     (key_reg),
            .data_q    (data_reg),
            .hit_rank  (hit_rank_reg),
            .hit_in    (hit_chain[i]),
            .hit_out   (hit_chain[i+1]),
            .free_in   (free_chain[i]),
            .free_out  (free_chain[i+1]),
            .rank_in   (rank_chain[i]),
            .rank_out  (rank_chain[i+1]),
            .rdata_in  (rdata_chain[i]),
            .rdata_out (rdata_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_UPDT);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= func;
            key_reg  <= key;
            data_reg <= data_in;
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg      <= hit_chain[CAPACITY];
            full_reg     <= !free_chain[CAPACITY];
            hit_rank_reg <= rank_chain[CAPACITY];
            hit_data_reg <= rdata_chain[CAPACITY];
        end
        if (state_reg == ST_UPDT)
        begin
            found_reg    <= op_valid && hit_reg;
            data_out_reg <= ((op_reg == OP_GET) && hit_reg) ? hit_data_reg : '0;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign data_out = data_out_reg;

endmodule

// ----- rtl/lkvc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cell
// One cache entry: key, value, valid and recency rank, plus its links in the
// hit, free-slot, rank and read-data chains.
// ----------------------------------------------------------------------------
module lkvc_cell #(
    parameter int CAPACITY  = lkvc_pkg::CAPACITY_DEF,
    parameter int KEY_BITS  = lkvc_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = lkvc_pkg::DATA_BITS_DEF,
    parameter int RANK_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lkvc_pkg::cell_ctrl_t ctrl,
    input  logic [KEY_BITS-1:0]  key_q,
    input  logic [DATA_BITS-1:0] data_q,
    input  logic [RANK_BITS-1:0] hit_rank,
    input  logic                 hit_in,
    output logic                 hit_out,
    input  logic                 free_in,
    output logic                 free_out,
    input  logic [RANK_BITS-1:0] rank_in,
    output logic [RANK_BITS-1:0] rank_out,
    input  logic [DATA_BITS-1:0] rdata_in,
    output logic [DATA_BITS-1:0] rdata_out
);
    import lkvc_pkg::*;

    localparam logic [RANK_BITS-1:0] LRU_RANK = RANK_BITS'(CAPACITY - 1);

    logic                 valid_reg, valid_next;
    logic [RANK_BITS-1:0] rank_reg,  rank_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic                 match_reg, free_sel_reg, lru_sel_reg;
    logic                 match, free_sel, lru_sel, target;

    assign match    = valid_reg && (key_reg == key_q);
    assign free_sel = !valid_reg && !free_in;   // lowest free slot wins
    assign lru_sel  = valid_reg && (rank_reg == LRU_RANK);

    assign hit_out   = hit_in | match;
    assign free_out  = free_in | !valid_reg;
    assign rank_out  = rank_in | (match ? rank_reg : '0);
    assign rdata_out = rdata_in | (match ? data_reg : '0);

    assign target = ctrl.put_new && (ctrl.use_lru ? lru_sel_reg : free_sel_reg);

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (target)
        begin
            valid_next = 1'b1;
            rank_next  = '0;
        end
        else if (ctrl.put_new && valid_reg)
        begin
            rank_next = rank_reg + 1'b1;
        end
        else if (ctrl.get_hit)
        begin
            if (match_reg)
                rank_next = '0;
            else if (valid_reg && (rank_reg < hit_rank))
                rank_next = rank_reg + 1'b1;
        end
        else if (ctrl.erase_hit)
        begin
            if (match_reg)
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
            else if (valid_reg && (rank_reg > hit_rank))
            begin
                rank_next = rank_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            rank_reg     <= '0;
            match_reg    <= 1'b0;
            free_sel_reg <= 1'b0;
            lru_sel_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            if (ctrl.look)
            begin
                match_reg    <= match;
                free_sel_reg <= free_sel;
                lru_sel_reg  <= lru_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (target)
        begin
            key_reg  <= key_q;
            data_reg <= data_q;
        end
    end

endmodule

// ----- rtl/lkvc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks on the issue/result timing of the LRU cache.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_unit_macros.svh"

module lkvc_checker #(
    parameter int DATA_BITS = lkvc_pkg::DATA_BITS_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 found,
    input logic [DATA_BITS-1:0] data_out
);

    `LKVC_ASSERT_NEXT(a_issue_busy, start && !busy, busy, "issued item did not raise busy")
    `LKVC_ASSERT_NOW(a_result_lat, start && !busy, ##3 done, "result not three cycles after issue")
    `LKVC_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
    `LKVC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `LKVC_ASSERT_NOW(a_miss_zero, done && !found, data_out == '0, "non-zero data on a miss")

endmodule

bind lru_key_value_cache_unit lkvc_checker #(.DATA_BITS(DATA_BITS)) u_lkvc_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key/value cache: a behavioural copy of the
// store with its recency ranks forecasts found/data_out for every accepted
// item, and each done strobe is checked in order against that forecast.
// ----------------------------------------------------------------------------
module tb_top;

    import lkvc_pkg::*;

    localparam int CAP    = CAPACITY_DEF;
    localparam int KEY_W  = KEY_BITS_DEF;
    localparam int DATA_W = DATA_BITS_DEF;

    // func 3 has no meaning; the cache must answer not-found and do nothing
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int N_RANDOM   = 1050;
    localparam int POOL_SIZE  = 12;

    typedef struct {
        bit                hit;
        logic [DATA_W-1:0] value;
    } cache_reply_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the store plus the queue of forecast replies
    // ------------------------------------------------------------------------
    class lru_scoreboard;

        bit                shadow_valid[CAP];
        logic [KEY_W-1:0]  shadow_key[CAP];
        logic [DATA_W-1:0] shadow_data[CAP];
        int unsigned       shadow_rank[CAP];   // 0 = most recent
        cache_reply_t      pending_replies[$];
        int                mismatches;

        function new();
            for (int i = 0; i < CAP; i++)
            begin
                shadow_valid[i] = 1'b0;
                shadow_rank[i]  = 0;
            end
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("%0t ns  MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        // Apply one accepted item to the shadow store, queue its reply
        function void note_access(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                  input logic [DATA_W-1:0] d);
            cache_reply_t rep;
            int           hit_slot;
            int           slot;
            int unsigned  r;
            rep.hit   = 1'b0;
            rep.value = '0;
            hit_slot  = -1;
            for (int i = 0; i < CAP; i++)
            begin
                if (shadow_valid[i] && shadow_key[i] == k)
                    hit_slot = i;
            end
            case (op)
                OP_PUT:
                begin
                    if (hit_slot >= 0)
                        rep.hit = 1'b1;     // rejected: nothing moves
                    else
                    begin
                        slot = -1;
                        for (int i = 0; i < CAP; i++)
                        begin
                            if (!shadow_valid[i] && slot < 0)
                                slot = i;
                        end
                        if (slot < 0)
                        begin
                            // full: evict the least recent entry
                            for (int i = 0; i < CAP; i++)
                            begin
                                if (shadow_rank[i] == CAP - 1)
                                    slot = i;
                            end
                            if (slot < 0)
                                slot = 0;
                            shadow_valid[slot] = 1'b0;
                        end
                        for (int i = 0; i < CAP; i++)
                        begin
                            if (shadow_valid[i])
                                shadow_rank[i]++;
                        end
                        shadow_valid[slot] = 1'b1;
                        shadow_key[slot]   = k;
                        shadow_data[slot]  = d;
                        shadow_rank[slot]  = 0;
                    end
                end
                OP_GET:
                begin
                    if (hit_slot >= 0)
                    begin
                        r = shadow_rank[hit_slot];
                        for (int i = 0; i < CAP; i++)
                        begin
                            if (shadow_valid[i] && shadow_rank[i] < r)
                                shadow_rank[i]++;
                        end
                        shadow_rank[hit_slot] = 0;
                        rep.hit   = 1'b1;
                        rep.value = shadow_data[hit_slot];
                    end
                end
                OP_ERASE:
                begin
                    if (hit_slot >= 0)
                    begin
                        r = shadow_rank[hit_slot];
                        shadow_valid[hit_slot] = 1'b0;
                        shadow_rank[hit_slot]  = 0;
                        for (int i = 0; i < CAP; i++)
                        begin
                            if (shadow_valid[i] && shadow_rank[i] > r)
                                shadow_rank[i]--;
                        end
                        rep.hit = 1'b1;
                    end
                end
                default: ;
            endcase
            pending_replies.push_back(rep);
        endfunction

        task check_reply(input logic hit, input logic [DATA_W-1:0] value);
            cache_reply_t exp_rep;
            if (pending_replies.size() == 0)
                report_mismatch($sformatf("result with none expected (found=%b data=%h)",
                                          hit, value));
            else
            begin
                exp_rep = pending_replies.pop_front();
                if (hit !== exp_rep.hit)
                    report_mismatch($sformatf("found %b, expected %b", hit, exp_rep.hit));
                if (value !== exp_rep.value)
                    report_mismatch($sformatf("data_out %h, expected %h",
                                              value, exp_rep.value));
            end
        endtask

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic [1:0]        func    = OP_PUT;
    logic [KEY_W-1:0]  key     = '0;
    logic [DATA_W-1:0] data_in = '0;
    logic              busy;
    logic              done;
    logic              found;
    logic [DATA_W-1:0] data_out;

    lru_scoreboard     sb = new();
    bit                idle_on;
    logic [KEY_W-1:0]  key_pool[POOL_SIZE];

    always #5 clk = ~clk;

    lru_key_value_cache_unit #(
        .CAPACITY  (CAP),
        .KEY_BITS  (KEY_W),
        .DATA_BITS (DATA_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .key      (key),
        .data_in  (data_in),
        .done     (done),
        .found    (found),
        .data_out (data_out)
    );

    // Results cannot be held off, so every done strobe is taken as it comes.
    // Sampling in the active region of the edge sees pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply(found, data_out);
    end

    // ------------------------------------------------------------------------
    // Item driver: hold start and the fields until an edge sees busy low,
    // then optionally drop start for an idle burst.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] k,
                             input logic [DATA_W-1:0] d);
        start   <= 1'b1;
        func    <= op;
        key     <= k;
        data_in <= d;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_access(op, k, d);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Mostly pool keys so that hits, rejected puts and evictions are common;
    // a few keys from anywhere keep misses and all key bits alive.
    task automatic send_random_item();
        logic [1:0]       op;
        logic [KEY_W-1:0] k;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_PUT;
        else if (pick < 75)
            op = OP_GET;
        else if (pick < 95)
            op = OP_ERASE;
        else
            op = OP_UNUSED;
        if ($urandom_range(0, 19) == 0)
            k = $urandom;
        else
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        // slowly rotate the pool so the store sees fresh keys
        if ($urandom_range(0, 63) == 0)
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        send_item(op, k, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int wait_cycles;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        idle_on = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-store misses, unused func, extreme keys and values
        send_item(OP_GET,    32'h0000_0000, 32'h0000_0000);
        send_item(OP_ERASE,  32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_PUT,    32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_PUT,    32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_PUT,    32'h0000_0000, 32'h0000_1234);    // rejected put
        send_item(OP_GET,    32'h0000_0000, 32'h0000_0000);
        send_item(OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_ERASE,  32'h0000_0000, 32'h0000_0000);    // erase hit
        send_item(OP_GET,    32'h0000_0000, 32'h0000_0000);    // miss after erase
        // fill the store; the freed slot 0 is reused first
        for (int i = 1; i <= 7; i++)
            send_item(OP_PUT, i, 32'hA5A5_0000 + i);
        // refresh the oldest so key 1 becomes least recent, then evict it
        send_item(OP_GET,    32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_PUT,    32'h0000_0064, 32'h5A5A_5A5A);
        send_item(OP_GET,    32'h0000_0001, 32'h0000_0000);    // evicted
        send_item(OP_GET,    32'h0000_0002, 32'h0000_0000);
        send_item(OP_PUT,    32'h0000_0065, 32'h0F0F_0F0F);    // evicts key 3
        send_item(OP_ERASE,  32'h0000_0005, 32'h0000_0000);    // hole in the middle
        send_item(OP_PUT,    32'h0000_0066, 32'hF0F0_F0F0);    // takes the hole
        send_item(OP_UNUSED, 32'h0000_0066, 32'h1111_1111);    // present key, no effect

        // Random: idle bursts with one calm stretch, none at all at the end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            idle_on = !((n >= 400 && n < 550) || n >= N_RANDOM - 150);
            send_random_item();
        end
        start <= 1'b0;

        // Drain, then allow a few cycles for any stray strobe
        wait_cycles = 0;
        while (sb.pending_replies.size() != 0 && wait_cycles < 200)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending_replies.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.pending_replies.size()));

        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache_unit.sv
rtl/lkvc_checker.sv
tb/tb_top.sv
